FILE: hdl/urfrm_pkg.sv
// shared item types, status codes and reply keywords for the receive fifo
package urfrm_pkg;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    localparam logic KIND_PUSH = 1'b0;
    localparam logic KIND_POP  = 1'b1;

    localparam logic [15:0] KEY_OK      = 16'h4F4B;
    localparam logic [31:0] KEY_IPD     = 32'h2B49_5044;
    localparam logic [47:0] KEY_CLOSED  = 48'h434C_4F53_4544;
    localparam logic [55:0] KEY_SEND_OK = 56'h5345_4E44_204F_4B;

    typedef struct packed {
        logic       kind;
        logic [1:0] channel;
        logic [7:0] rx_byte;
    } t_in_item;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] read_byte;
        logic       saw_ok;
        logic       saw_closed;
        logic       saw_send_ok;
        logic       saw_ipd;
    } t_out_item;

    // what the matcher needs to know about the item in the result stage
    typedef struct packed {
        logic       pop_ok;
        logic [1:0] channel;
    } t_pop_info;

    typedef struct packed {
        logic saw_ok;
        logic saw_closed;
        logic saw_send_ok;
        logic saw_ipd;
    } t_match;

endpackage

FILE: hdl/urfrm_ring.sv
// per-channel ring pointers and the shared byte memory
module urfrm_ring #(
    parameter int DEPTH    = 64,
    parameter int CHANNELS = 3
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  urfrm_pkg::t_in_item i_item,
    output logic [1:0]        o_status,
    output logic [7:0]        o_rd_data
);
    import urfrm_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int AW = $clog2(CHANNELS * DEPTH);
    localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int XW = (CW > 2) ? CW : 2;

    logic [PW-1:0] r_rptr [CHANNELS];
    logic [PW-1:0] r_wptr [CHANNELS];
    logic [7:0]    r_mem  [CHANNELS*DEPTH];
    logic [7:0]    r_rd_data;

    logic [XW-1:0] ch_ext;
    logic [CW-1:0] ch_idx;
    logic          ch_ok;
    logic [PW-1:0] cur_r;
    logic [PW-1:0] cur_w;
    logic [PW-1:0] next_r;
    logic [PW-1:0] next_w;
    logic          push_ok;
    logic          pop_ok;
    logic [AW-1:0] addr;

    always_comb begin
        ch_ext  = XW'(i_item.channel);
        ch_idx  = ch_ext[CW-1:0];
        ch_ok   = (int'(ch_ext) < CHANNELS);
        cur_r   = ch_ok ? r_rptr[ch_idx] : '0;
        cur_w   = ch_ok ? r_wptr[ch_idx] : '0;
        next_r  = (cur_r == PW'(DEPTH - 1)) ? '0 : cur_r + PW'(1);
        next_w  = (cur_w == PW'(DEPTH - 1)) ? '0 : cur_w + PW'(1);
        push_ok = ch_ok && (next_w != cur_r);
        pop_ok  = ch_ok && (cur_r != cur_w);
        if (i_item.kind == KIND_POP) begin
            o_status = pop_ok ? ST_DONE : ST_EMPTY;
            addr     = AW'(int'(ch_idx) * DEPTH + int'(cur_r));
        end else begin
            o_status = push_ok ? ST_DONE : ST_FULL;
            addr     = AW'(int'(ch_idx) * DEPTH + int'(cur_w));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < CHANNELS; c++) begin
                r_rptr[c] <= '0;
                r_wptr[c] <= '0;
            end
        end else if (i_fire) begin
            if (i_item.kind == KIND_POP && pop_ok) begin
                r_rptr[ch_idx] <= next_r;
            end
            if (i_item.kind == KIND_PUSH && push_ok) begin
                r_wptr[ch_idx] <= next_w;
            end
        end
    end

    // write on a successful push, and a registered read on every fired item; only a pop's read data is used
    always_ff @(posedge i_clk) begin
        if (i_fire && i_item.kind == KIND_PUSH && push_ok) begin
            r_mem[addr] <= i_item.rx_byte;
        end
        if (i_fire) begin
            r_rd_data <= r_mem[addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: hdl/urfrm_match.sv
// per-channel history of popped bytes and the reply keyword compare
module urfrm_match #(
    parameter int CHANNELS = 3
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_retire,
    input  urfrm_pkg::t_pop_info i_pop,
    input  logic [7:0]           i_rd_data,
    output urfrm_pkg::t_match    o_match
);
    import urfrm_pkg::*;

    localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int XW = (CW > 2) ? CW : 2;

    logic [55:0]   r_hist [CHANNELS];
    logic [XW-1:0] ch_ext;
    logic [CW-1:0] ch_idx;
    logic [55:0]   cur_hist;
    logic [55:0]   new_hist;

    always_comb begin
        ch_ext   = XW'(i_pop.channel);
        ch_idx   = ch_ext[CW-1:0];
        // pop_ok is only ever set for a channel that exists
        cur_hist = i_pop.pop_ok ? r_hist[ch_idx] : '0;
        new_hist = {cur_hist[47:0], i_rd_data};
        o_match.saw_ok      = i_pop.pop_ok && (new_hist[15:0] == KEY_OK);
        o_match.saw_ipd     = i_pop.pop_ok && (new_hist[31:0] == KEY_IPD);
        o_match.saw_closed  = i_pop.pop_ok && (new_hist[47:0] == KEY_CLOSED);
        o_match.saw_send_ok = i_pop.pop_ok && (new_hist == KEY_SEND_OK);
    end

    // history advances only when the popped item leaves the result stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < CHANNELS; c++) begin
                r_hist[c] <= '0;
            end
        end else if (i_retire && i_pop.pop_ok) begin
            r_hist[ch_idx] <= new_hist;
        end
    end

endmodule

FILE: hdl/uart_rx_fifo_with_reply_matcher.sv
// Multi-channel receive byte fifo with modem reply keyword detection.
// Input channel (i_in_valid / o_in_ready / i_in_item): each item either
// pushes rx_byte into the selected channel's ring or pops its oldest byte.
// Output channel (o_out_valid / i_out_ready / o_out_item): exactly one
// result item per input item, in order, carrying status, the popped byte
// and the OK, CLOSED, SEND OK and +IPD flags for the popped byte stream.
// Each ring holds DEPTH-1 bytes; a push to a full ring or a pop from an
// empty ring (or any access to a channel not present) leaves state alone
// and reports it in status.
// From input accept to result valid an item passes the input register,
// where pointers are checked and the ring memory is written or read,
// and the result stage, where the registered read data meets the
// per-channel history. Throughput is one item per cycle when not stalled.
// Reset clears all pointers and histories at once; the ring memory needs
// no clearing. When the receiver stalls, the result stage holds and the
// input register fills; o_in_ready drops only when both stages are full.
module uart_rx_fifo_with_reply_matcher #(
    parameter int DEPTH    = 64,
    parameter int CHANNELS = 3
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  urfrm_pkg::t_in_item   i_in_item,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output urfrm_pkg::t_out_item  o_out_item
);
    import urfrm_pkg::*;

    logic       r_a_valid;
    t_in_item   r_a;
    logic       r_b_valid;
    logic [1:0] r_b_status;
    t_pop_info  r_b_pop;

    logic       advance;
    logic       fire;
    logic       retire;
    logic [1:0] a_status;
    logic [7:0] rd_data;
    t_match     match;

    assign advance    = !r_b_valid || i_out_ready;
    assign fire       = r_a_valid && advance;
    assign retire     = r_b_valid && i_out_ready;
    assign o_in_ready = !r_a_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_a_valid <= i_in_valid;
            end
            if (advance) begin
                r_b_valid <= r_a_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_a <= i_in_item;
        end
        if (fire) begin
            r_b_status     <= a_status;
            r_b_pop.pop_ok <= (r_a.kind == KIND_POP) && (a_status == ST_DONE);
            r_b_pop.channel <= r_a.channel;
        end
    end

    urfrm_ring #(
        .DEPTH    (DEPTH),
        .CHANNELS (CHANNELS)
    ) u_ring (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_fire    (fire),
        .i_item    (r_a),
        .o_status  (a_status),
        .o_rd_data (rd_data)
    );

    urfrm_match #(
        .CHANNELS (CHANNELS)
    ) u_match (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_retire  (retire),
        .i_pop     (r_b_pop),
        .i_rd_data (rd_data),
        .o_match   (match)
    );

    assign o_out_valid            = r_b_valid;
    assign o_out_item.status      = r_b_status;
    assign o_out_item.read_byte   = r_b_pop.pop_ok ? rd_data : 8'd0;
    assign o_out_item.saw_ok      = match.saw_ok;
    assign o_out_item.saw_closed  = match.saw_closed;
    assign o_out_item.saw_send_ok = match.saw_send_ok;
    assign o_out_item.saw_ipd     = match.saw_ipd;

endmodule

FILE: hdl/urfrm_checker.sv
// port-level checks for the receive fifo, bound to the top level
module urfrm_checker (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_out_valid,
    input logic                 i_out_ready,
    input urfrm_pkg::t_out_item o_out_item
);
    import urfrm_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item))
        else $error("result changed while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // keyword flags only on a successful pop
    a_flags_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_item.saw_ok || o_out_item.saw_closed ||
            o_out_item.saw_send_ok || o_out_item.saw_ipd)
        |-> o_out_item.status == ST_DONE)
        else $error("keyword flag without a successful pop");

    // send ok ends in ok
    a_send_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.saw_send_ok |-> o_out_item.saw_ok)
        else $error("send ok seen without ok");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.status != ST_DONE |->
            o_out_item.read_byte == 8'd0)
        else $error("byte returned on a failed item");

endmodule

bind uart_rx_fifo_with_reply_matcher urfrm_checker u_urfrm_checker (.*);
